[rtl/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg
// shared types, constants and helper functions for the epoch seconds to
// calendar converter
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int unsigned DAYS_W = 16;
    localparam int unsigned YEAR_W = 13;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // reciprocals rounded up: 2^35 / 675, 2^21 / 225, 2^14 / 15
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    localparam logic [11:0] BASE_YEAR_RESET = 12'd2000;
    localparam logic [3:0]  LAST_MONTH      = 4'd11;
    localparam logic [3:0]  FEBRUARY        = 4'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY_QUO,
        ST_DAY_REM,
        ST_HOUR_QUO,
        ST_HOUR_REM,
        ST_MIN_QUO,
        ST_MIN_REM,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic day_quo;
        logic day_rem;
        logic hour_quo;
        logic hour_rem;
        logic min_quo;
        logic min_rem;
        logic year_step;
        logic month_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
    } status_t;

    function automatic logic [8:0] year_mod400(input logic [11:0] y);
        logic [11:0] v;
        v = y;
        if (v >= 12'd3200) v = v - 12'd3200;
        if (v >= 12'd1600) v = v - 12'd1600;
        if (v >= 12'd800)  v = v - 12'd800;
        if (v >= 12'd400)  v = v - 12'd400;
        return v[8:0];
    endfunction

    function automatic logic [6:0] year_mod100(input logic [8:0] y400);
        logic [8:0] v;
        v = y400;
        if (v >= 9'd200) v = v - 9'd200;
        if (v >= 9'd100) v = v - 9'd100;
        return v[6:0];
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            FEBRUARY:                d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

[rtl/epoch_seconds_to_calendar_unit.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// converts a 32-bit seconds count since january 1 of base_year into a
// gregorian date and time of day
// ----------------------------------------------------------------------------
// One item is worked on at a time. After accept, the divisions by 86400, 3600
// and 60 each take a reciprocal multiply step and a remainder step. The year
// walk then steps past base_year by up to 136 whole years and the month walk
// by up to 11 whole months within the final year, one year or month per
// cycle, each walk with an exit step, and a last step loads the result once
// the output register is free. The next request is taken in the cycle after
// the result is loaded. A finished result waits in an output register, so
// the next request is taken while it is still stalled. base_year resets to
// 2000 and is written with cfg_write_en while the unit is idle; the user must
// keep to this, as the unit itself does not enforce it.
module epoch_seconds_to_calendar_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [11:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] seconds_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);
    import esc_pkg::*;

    cmd_t    cmd;
    status_t status;

    esc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    esc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .seconds_count  (seconds_count),
        .cmd            (cmd),
        .status         (status),
        .year           (year),
        .month          (month),
        .day_of_month   (day_of_month),
        .hour           (hour),
        .minute         (minute),
        .second         (second)
    );

endmodule

[rtl/esc_ctrl.sv]
// ----------------------------------------------------------------------------
// esc_ctrl
// sequencer for the converter: runs the three divisions, the year walk and
// the month walk, and owns both handshakes
// ----------------------------------------------------------------------------
module esc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  esc_pkg::status_t status,
    output esc_pkg::cmd_t   cmd
);
    import esc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_DAY_QUO;
            ST_DAY_QUO:  state_next = ST_DAY_REM;
            ST_DAY_REM:  state_next = ST_HOUR_QUO;
            ST_HOUR_QUO: state_next = ST_HOUR_REM;
            ST_HOUR_REM: state_next = ST_MIN_QUO;
            ST_MIN_QUO:  state_next = ST_MIN_REM;
            ST_MIN_REM:  state_next = ST_YEAR;
            ST_YEAR:     if (!status.year_fit) state_next = ST_MONTH;
            ST_MONTH:    if (!status.month_fit) state_next = ST_FINISH;
            ST_FINISH:   if (slot_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_DAY_QUO:
            begin
                cmd.day_quo = 1'b1;
            end
            ST_DAY_REM:
            begin
                cmd.day_rem = 1'b1;
            end
            ST_HOUR_QUO:
            begin
                cmd.hour_quo = 1'b1;
            end
            ST_HOUR_REM:
            begin
                cmd.hour_rem = 1'b1;
            end
            ST_MIN_QUO:
            begin
                cmd.min_quo = 1'b1;
            end
            ST_MIN_REM:
            begin
                cmd.min_rem = 1'b1;
            end
            ST_YEAR:
            begin
                cmd.year_step = status.year_fit;
            end
            ST_MONTH:
            begin
                cmd.month_step = status.month_fit;
            end
            ST_FINISH:
            begin
                cmd.out_load = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

[rtl/esc_dp.sv]
// ----------------------------------------------------------------------------
// esc_dp
// datapath: base year register, reciprocal constant dividers, year and month
// walk registers and the result register
// ----------------------------------------------------------------------------
module esc_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write_en,
    input  logic [11:0]     cfg_write_data,
    input  logic [31:0]     seconds_count,
    input  esc_pkg::cmd_t   cmd,
    output esc_pkg::status_t status,
    output logic [11:0]     year,
    output logic [3:0]      month,
    output logic [4:0]      day_of_month,
    output logic [4:0]      hour,
    output logic [5:0]      minute,
    output logic [5:0]      second
);
    import esc_pkg::*;

    logic [11:0]       base_year_reg;
    logic [31:0]       sec_reg;
    logic [16:0]       tod_reg;
    logic [11:0]       rest_reg;
    logic [50:0]       day_prod;
    logic [16:0]       day_mul_lo;
    logic [25:0]       hour_prod;
    logic [11:0]       hour_mul_lo;
    logic [19:0]       min_prod;
    logic [5:0]        min_mul_lo;

    logic [DAYS_W-1:0] days_reg, days_next;
    logic [YEAR_W-1:0] y_reg, y_next;
    logic [8:0]        y400_reg, y400_next;
    logic [6:0]        y100_reg, y100_next;
    logic [3:0]        m_reg, m_next;
    logic [4:0]        hour_reg;
    logic [5:0]        minute_reg;
    logic [5:0]        second_reg;
    logic              leap;
    logic [8:0]        year_len;
    logic [4:0]        cur_month_len;

    logic [11:0]       year_out_reg;
    logic [3:0]        month_out_reg;
    logic [4:0]        day_out_reg;
    logic [4:0]        hour_out_reg;
    logic [5:0]        minute_out_reg;
    logic [5:0]        second_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_year_reg <= BASE_YEAR_RESET;
        else if (cfg_write_en)
            base_year_reg <= cfg_write_data;
    end

    // constant divisions by reciprocal multiply, one step a cycle
    assign day_prod    = {26'd0, sec_reg[31:7]} * {25'd0, DAY_RECIP};
    assign day_mul_lo  = {1'b0, days_reg} * SECS_PER_DAY;
    assign hour_prod   = {13'd0, tod_reg[16:4]} * {12'd0, HOUR_RECIP};
    assign hour_mul_lo = {7'd0, hour_reg} * SECS_PER_HOUR;
    assign min_prod    = {10'd0, rest_reg[11:2]} * {9'd0, MIN_RECIP};
    assign min_mul_lo  = minute_reg * SECS_PER_MIN;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sec_reg <= seconds_count;
        if (cmd.day_rem)
            tod_reg <= sec_reg[16:0] - day_mul_lo;
        if (cmd.hour_quo)
            hour_reg <= hour_prod[25:21];
        if (cmd.hour_rem)
            rest_reg <= tod_reg[11:0] - hour_mul_lo;
        if (cmd.min_quo)
            minute_reg <= min_prod[19:14];
        if (cmd.min_rem)
            second_reg <= rest_reg[5:0] - min_mul_lo;
    end

    // calendar walk
    assign leap          = (y400_reg == 9'd0) || ((y100_reg != 7'd0) && (y_reg[1:0] == 2'd0));
    assign year_len      = leap ? 9'd366 : 9'd365;
    assign cur_month_len = month_len(m_reg, leap);

    always_comb
    begin
        days_next = days_reg;
        y_next    = y_reg;
        y400_next = y400_reg;
        y100_next = y100_reg;
        m_next    = m_reg;
        priority if (cmd.load)
        begin
            y_next    = {1'b0, base_year_reg};
            y400_next = year_mod400(base_year_reg);
            y100_next = year_mod100(year_mod400(base_year_reg));
            m_next    = '0;
        end
        else if (cmd.day_quo)
        begin
            days_next = day_prod[50:35];
        end
        else if (cmd.year_step)
        begin
            days_next = days_reg - DAYS_W'(year_len);
            y_next    = y_reg + YEAR_W'(1);
            y400_next = (y400_reg == 9'd399) ? 9'd0 : y400_reg + 9'd1;
            y100_next = (y100_reg == 7'd99) ? 7'd0 : y100_reg + 7'd1;
        end
        else if (cmd.month_step)
        begin
            days_next = days_reg - DAYS_W'(cur_month_len);
            m_next    = m_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        days_reg <= days_next;
        y_reg    <= y_next;
        y400_reg <= y400_next;
        y100_reg <= y100_next;
        m_reg    <= m_next;
    end

    assign status.year_fit  = (days_reg >= DAYS_W'(year_len));
    assign status.month_fit = (m_reg < LAST_MONTH) && (days_reg >= DAYS_W'(cur_month_len));

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            year_out_reg   <= y_reg[11:0];
            month_out_reg  <= m_reg + 4'd1;
            day_out_reg    <= days_reg[4:0] + 5'd1;
            hour_out_reg   <= hour_reg;
            minute_out_reg <= minute_reg;
            second_out_reg <= second_reg;
        end
    end

    assign year         = year_out_reg;
    assign month        = month_out_reg;
    assign day_of_month = day_out_reg;
    assign hour         = hour_out_reg;
    assign minute       = minute_out_reg;
    assign second       = second_out_reg;

endmodule

[test/epoch_seconds_to_calendar_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit_tb
// Self-checking bench for the seconds-to-calendar converter. Every accepted
// request is converted by a behavioral Gregorian calendar walk and queued.
// Each returned date and time is compared field by field with the oldest
// queued value. Coverage comes from directed edge dates, base years at and
// beyond the usual range, and long random runs with idle gaps on both sides.
// Pressure cases include a long output hold and pauses that drain all results.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit_tb;

    localparam int unsigned DAY_SECS         = 86400;
    localparam int unsigned HOUR_SECS        = 3600;
    localparam int unsigned MINUTE_SECS      = 60;
    localparam int unsigned LAST_DAY_INDEX   = 49709;
    localparam logic [11:0] RESET_BASE_YEAR  = 12'd2000;
    localparam int unsigned CYCLE_LIMIT      = 3000000;
    localparam int unsigned SETTLE_CYCLES    = 250;
    localparam int unsigned LONG_HOLD_CYCLES = 900;
    localparam int unsigned RANDOM_PHASES    = 10;
    localparam int unsigned PHASE_REQUESTS   = 105;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [11:0] cfg_write_data = '0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [31:0] seconds_count  = '0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    calendar_t   pending_dates [$];
    logic [11:0] model_base_year = RESET_BASE_YEAR;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    bit          sender_idles    = 1'b0;
    bit          receiver_idles  = 1'b0;
    int unsigned hold_cycles     = 0;

    epoch_seconds_to_calendar_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .seconds_count  (seconds_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .year           (year),
        .month          (month),
        .day_of_month   (day_of_month),
        .hour           (hour),
        .minute         (minute),
        .second         (second)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned year_days(input int unsigned y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
        case (m)
            1:           return leap ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic calendar_t to_calendar(input logic [31:0] secs,
                                              input logic [11:0] base);
        int unsigned time_of_day;
        int unsigned days;
        int unsigned y;
        int unsigned m;
        int unsigned len;
        bit          leap;
        calendar_t   date;
        time_of_day = secs % DAY_SECS;
        days        = secs / DAY_SECS;
        y           = 32'(base);
        m           = 0;
        len         = year_days(y);
        while (days >= len)
        begin
            days = days - len;
            y    = y + 1;
            len  = year_days(y);
        end
        leap = is_leap_year(y);
        len  = days_in_month(m, leap);
        while (m < 11 && days >= len)
        begin
            days = days - len;
            m    = m + 1;
            len  = days_in_month(m, leap);
        end
        date.year         = y[11:0];
        date.month        = 4'(m + 1);
        date.day_of_month = 5'(days + 1);
        date.hour         = 5'(time_of_day / HOUR_SECS);
        date.minute       = 6'((time_of_day % HOUR_SECS) / MINUTE_SECS);
        date.second       = 6'(time_of_day % MINUTE_SECS);
        return date;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic int unsigned idle_cycles();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 4);
        if (roll < 97)
            return $urandom_range(5, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic logic [31:0] random_seconds();
        int unsigned roll;
        int unsigned day_index;
        roll      = $urandom_range(0, 9);
        day_index = $urandom_range(0, LAST_DAY_INDEX);
        case (roll)
            0, 1, 2, 3: return $urandom;
            4, 5:       return $urandom_range(0, 3 * 365 * DAY_SECS);
            6, 7:       return day_index * DAY_SECS + $urandom_range(0, 1) * (DAY_SECS - 1);
            8:          return 32'hFFFF_FFFF - $urandom_range(0, 400 * DAY_SECS);
            default:    return day_index * DAY_SECS + $urandom_range(0, 23) * HOUR_SECS
                               + $urandom_range(0, 1) * (HOUR_SECS - 1);
        endcase
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // request tracking and result checking
    always @(posedge clk)
    begin : check_dates
        calendar_t want;
        if (rst_n)
        begin
            if (cfg_write_en)
                model_base_year = cfg_write_data;
            if (in_valid && !in_stall)
                pending_dates.push_back(to_calendar(seconds_count, model_base_year));
            if (out_valid && !out_stall)
            begin
                if (pending_dates.size() == 0)
                begin
                    $error("result with no request pending: %0d-%0d-%0d %0d:%0d:%0d",
                           year, month, day_of_month, hour, minute, second);
                    error_count++;
                end
                else
                begin
                    want = pending_dates.pop_front();
                    check_field("year", 32'(want.year), 32'(year));
                    check_field("month", 32'(want.month), 32'(month));
                    check_field("day_of_month", 32'(want.day_of_month), 32'(day_of_month));
                    check_field("hour", 32'(want.hour), 32'(hour));
                    check_field("minute", 32'(want.minute), 32'(minute));
                    check_field("second", 32'(want.second), 32'(second));
                end
            end
        end
    end

    // result side stall
    initial
    begin : result_receiver
        int unsigned len;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                out_stall <= 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 2) == 0)
            begin
                len = 1 + idle_cycles();
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_request(input logic [31:0] secs);
        int unsigned gap;
        gap = sender_idles ? idle_cycles() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        seconds_count <= secs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_dates.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_base_year(input logic [11:0] value);
        drain_requests();
        repeat (4) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_base_edges();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        send_request(32'd0);
        send_request(DAY_SECS - 1);
        send_request(DAY_SECS);
        send_request(59 * DAY_SECS);
        send_request(60 * DAY_SECS - 1);
        send_request(365 * DAY_SECS + DAY_SECS - 1);
        send_request(366 * DAY_SECS);
        // century year that is not a leap year
        send_request((36525 + 58) * DAY_SECS);
        send_request((36525 + 59) * DAY_SECS);
        send_request(12 * HOUR_SECS + 34 * MINUTE_SECS + 56);
        send_request(32'hFFFF_FFFF);
        send_request(32'hAAAA_AAAA);
        send_request(32'h5555_5555);
        drain_requests();
    endtask

    task automatic test_base_year_extremes();
        set_base_year(12'd1970);
        send_request(32'd0);
        send_request(32'hFFFF_FFFF);
        set_base_year(12'd2099);
        send_request(32'd0);
        send_request(32'hFFFF_FFFF);
        // year zero counts as leap
        set_base_year(12'd0);
        send_request(59 * DAY_SECS);
        send_request(32'hFFFF_FFFF);
        // year wraps past 4095
        set_base_year(12'd4095);
        send_request(32'd0);
        send_request(365 * DAY_SECS);
        send_request(32'hFFFF_FFFF);
        set_base_year(12'd1900);
        send_request(59 * DAY_SECS);
        send_request(32'hFFFF_FFFF);
        set_base_year(12'd2400);
        send_request(59 * DAY_SECS);
        send_request(60 * DAY_SECS);
        drain_requests();
    endtask

    task automatic test_random_stream();
        logic [11:0] base;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                base = 12'd1970;
            else if (phase == 1)
                base = 12'd2099;
            else if ($urandom_range(0, 4) == 0)
                base = 12'($urandom_range(0, 4095));
            else
                base = 12'($urandom_range(1970, 2099));
            set_base_year(base);
            sender_idles   = phase[0];
            receiver_idles = phase[1];
            for (int unsigned n = 0; n < PHASE_REQUESTS; n++)
                send_request(random_seconds());
        end
        drain_requests();
    endtask

    task automatic test_long_output_hold();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        hold_cycles    = LONG_HOLD_CYCLES;
        for (int unsigned n = 0; n < 40; n++)
            send_request(random_seconds());
        drain_requests();
    endtask

    task automatic test_pause_until_drained();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        for (int unsigned burst = 0; burst < 3; burst++)
        begin
            for (int unsigned n = 0; n < 20; n++)
                send_request(random_seconds());
            drain_requests();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_base_edges();
        test_base_year_extremes();
        test_random_stream();
        test_long_output_hold();
        test_pause_until_drained();
        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_dates.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/esc_pkg.sv
rtl/esc_ctrl.sv
rtl/esc_dp.sv
rtl/epoch_seconds_to_calendar_unit.sv
test/epoch_seconds_to_calendar_unit_tb.sv
